// ===== hw/rtl/ppmbss_pkg.sv =====
`default_nettype none

package ppmbss_pkg;

    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int SIDE_W    = 14;
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int COUNT_W   = 31;
    // 255 * sample needs 24 bits for a 16-bit sample
    localparam int DVD_W     = SAMPLE_W + BYTE_W;
    localparam int PIXEL_W   = 3 * BYTE_W;

    localparam int QUEUE_DEPTH = 2;

    // component slots of the open pixel
    localparam logic [1:0] SLOT_RED   = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_BLUE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_VALUE    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [SAMPLE_W-1:0] MAX_VALUE_RESET = 16'd255;

    // one classified raster event handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                has_sample;
        logic [1:0]          slot;
        logic                fin;
        logic                ok;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppmbss_front.sv =====
`default_nettype none

module ppmbss_front
    import ppmbss_pkg::*;
#(
    parameter int MAX_SIDE = 16383
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,
    input  wire logic                s_tlast,
    input  wire logic [SAMPLE_W-1:0] max_value,
    input  wire logic [SIDE_W-1:0]   image_width,
    input  wire logic [SIDE_W-1:0]   image_height,
    input  wire logic                cfg_wr,
    input  wire logic                q_full,
    output logic                     push,
    output entry_t                   push_entry
);

    logic [COUNT_W-1:0]  bytes_reg;
    logic                ovr_reg;
    logic [BYTE_W-1:0]   high_reg;
    logic                await_reg;
    logic [1:0]          slot_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                hold_reg;

    logic [SIDE_W-1:0]   w_lim;
    logic [SIDE_W-1:0]   h_lim;
    logic [PROD_W+1:0]   exp3;
    logic [COUNT_W-1:0]  expected;
    logic                two_byte;
    logic                accept;
    logic                at_limit;
    logic [COUNT_W-1:0]  bytes_next;
    logic                ovr_next;
    logic                sample_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                pixel_ready;
    logic                ok;

    assign w_lim = ({18'd0, image_width} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_width;
    assign h_lim = ({18'd0, image_height} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_height;

    // x3 by shift and add, x6 one more shift
    assign exp3     = {2'b00, prod_reg} + {1'b0, prod_reg, 1'b0};
    assign two_byte = |max_value[SAMPLE_W-1:BYTE_W];
    assign expected = two_byte ? {exp3, 1'b0} : {1'b0, exp3};

    assign s_tready = !q_full && !hold_reg;
    assign accept   = s_tvalid && s_tready;

    assign at_limit   = &bytes_reg;
    assign bytes_next = at_limit ? bytes_reg : bytes_reg + 1'b1;
    assign ovr_next   = ovr_reg || at_limit;

    always_comb begin
        sample_ready = 1'b0;
        sample       = {{(SAMPLE_W-BYTE_W){1'b0}}, s_tdata};
        if (two_byte) begin
            sample_ready = await_reg;
            sample       = {high_reg, s_tdata};
        end else begin
            sample_ready = 1'b1;
        end
    end

    assign pixel_ready = sample_ready && (slot_reg == SLOT_BLUE);
    assign ok          = !ovr_next && (bytes_next == expected) && pixel_ready;

    assign push                  = accept && (sample_ready || s_tlast);
    assign push_entry.sample     = sample;
    assign push_entry.has_sample = sample_ready;
    assign push_entry.slot       = slot_reg;
    assign push_entry.fin        = s_tlast;
    assign push_entry.ok         = ok;

    // size product follows the registers in the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= {{SIDE_W{1'b0}}, w_lim} * {{SIDE_W{1'b0}}, h_lim};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= 1'b1;
            bytes_reg <= '0;
            ovr_reg   <= 1'b0;
            high_reg  <= '0;
            await_reg <= 1'b0;
            slot_reg  <= SLOT_RED;
        end else begin
            hold_reg <= cfg_wr;
            if (accept) begin
                if (s_tlast) begin
                    bytes_reg <= '0;
                    ovr_reg   <= 1'b0;
                    high_reg  <= '0;
                    await_reg <= 1'b0;
                    slot_reg  <= SLOT_RED;
                end else begin
                    bytes_reg <= bytes_next;
                    ovr_reg   <= ovr_next;
                    if (two_byte) begin
                        if (!await_reg) begin
                            high_reg <= s_tdata;
                        end
                        await_reg <= !await_reg;
                    end else begin
                        await_reg <= 1'b0;
                    end
                    if (sample_ready) begin
                        slot_reg <= (slot_reg == SLOT_BLUE) ? SLOT_RED : slot_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmbss_queue.sv =====
`default_nettype none

module ppmbss_queue
    import ppmbss_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output entry_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmbss_back.sv =====
`default_nettype none

module ppmbss_back
    import ppmbss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire entry_t              q_head,
    output logic                     q_pop,
    input  wire logic [SAMPLE_W-1:0] max_value,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [PIXEL_W-1:0]       m_tdata,
    output logic                     m_tlast,
    output logic                     m_tuser
);

    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } back_state_t;

    back_state_t          state_reg;
    entry_t               cur_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BYTE_W-1:0]    red_reg;
    logic [BYTE_W-1:0]    green_reg;
    logic                 m_valid_reg;
    logic [PIXEL_W-1:0]   m_data_reg;
    logic                 m_last_reg;
    logic                 m_user_reg;

    logic [SAMPLE_W-1:0]  divisor;
    logic [SAMPLE_W:0]    shifted;
    logic [SAMPLE_W+1:0]  diff;
    logic                 need_div;
    logic                 emit;
    logic                 out_free;
    logic                 load_out;
    logic [BYTE_W-1:0]    quot;

    assign divisor  = (max_value == '0) ? SAMPLE_W'(1) : max_value;
    assign shifted  = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, divisor};
    assign need_div = q_head.has_sample && (!q_head.fin || q_head.ok);
    assign quot     = dvd_reg[BYTE_W-1:0];

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign emit     = cur_reg.fin || (cur_reg.slot == SLOT_BLUE);
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_PUSH) && emit && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
            // 255 * sample as (sample << 8) - sample
            dvd_reg <= {q_head.sample, {BYTE_W{1'b0}}}
                       - {{BYTE_W{1'b0}}, q_head.sample};
            rem_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            rem_reg <= diff[SAMPLE_W+1] ? shifted[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], !diff[SAMPLE_W+1]};
        end
        if ((state_reg == ST_PUSH) && !cur_reg.fin) begin
            if (cur_reg.slot == SLOT_RED) begin
                red_reg <= quot;
            end
            if (cur_reg.slot == SLOT_GREEN) begin
                green_reg <= quot;
            end
        end
        if (load_out) begin
            m_data_reg <= (!cur_reg.fin || cur_reg.ok) ? {quot, green_reg, red_reg} : '0;
            m_last_reg <= cur_reg.fin;
            m_user_reg <= cur_reg.fin && !cur_reg.ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cnt_reg   <= '0;
                        state_reg <= need_div ? ST_DIV : ST_PUSH;
                    end
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DVD_W-1)) begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!emit || out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_binary_sample_scaler_unit.sv =====
// path: a byte that completes a sample reaches the result register through the queue
// (issue from the queue, 24 divide steps, then the write once the output is free)
// the bit-serial divider in the back end takes one sample at a time
// bytes that complete no sample and no image do not reach the divider
// reset: synchronous, active low; registers return to max_value 255, width and height 0;
// input is held off in the cycle after reset and after every register write
`default_nettype none

module ppm_binary_sample_scaler_unit
    import ppmbss_pkg::*;
#(
    parameter int MAX_SIDE = 16383
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // raster byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // final_byte

    // pixel stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             m_tlast,   // last_pixel
    output logic             m_tuser,   // status

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [SAMPLE_W-1:0] max_value_reg;
    logic [SIDE_W-1:0]   width_reg;
    logic [SIDE_W-1:0]   height_reg;
    logic                cfg_wr;
    logic [1:0]          reg_index;

    // front to back queue
    logic                q_push;
    entry_t              q_push_entry;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    entry_t              q_head;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // register write, index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= MAX_VALUE_RESET;
            width_reg     <= '0;
            height_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_index)
                REG_MAX_VALUE:    max_value_reg <= pwdata[SAMPLE_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= pwdata[SIDE_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= pwdata[SIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (reg_index)
            REG_MAX_VALUE:    prdata = {16'd0, max_value_reg};
            REG_IMAGE_WIDTH:  prdata = {18'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {18'd0, height_reg};
            default:          prdata = '0;
        endcase
    end

    // front end: byte count, sample assembly, slot tracking and size check
    ppmbss_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .max_value    (max_value_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cfg_wr       (cfg_wr),
        .q_full       (q_full),
        .push         (q_push),
        .push_entry   (q_push_entry)
    );

    // short queue so the front keeps taking bytes while the divider runs
    ppmbss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // back end: scaling divide, pixel assembly and output register
    ppmbss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .max_value (max_value_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
